// ----- rtl/cri_pkg.sv -----
// Package for the circle versus rotated rectangle test.
// Holds field widths, item structs, region codes and the CORDIC arctangent table.
// No dependencies.
`default_nettype none
package cri_pkg;
    localparam int CW    = 32;   // coordinate width
    localparam int AW    = 16;   // heading width
    localparam int STEPS = 30;   // CORDIC iterations
    localparam int XW    = 34;   // CORDIC x/y width, Q2.30 plus margin
    localparam int ZW    = 33;   // residual angle width
    localparam int KW    = 18;   // sine/cosine width, Q1.16 signed
    localparam int LW    = CW + 5;  // doubled local magnitude width
    localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);

    localparam logic [1:0] REGION_INSIDE = 2'd0;
    localparam logic [1:0] REGION_SIDE_Y = 2'd1;
    localparam logic [1:0] REGION_SIDE_X = 2'd2;
    localparam logic [1:0] REGION_CORNER = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] circle_x;
        logic signed [CW-1:0] circle_y;
        logic [CW-2:0]        circle_radius;
        logic signed [CW-1:0] rect_x;
        logic signed [CW-1:0] rect_y;
        logic [AW-1:0]        rect_heading;
        logic [CW-2:0]        rect_width;
        logic [CW-2:0]        rect_height;
    } t_in;

    typedef struct packed {
        logic       hit;
        logic [1:0] region;
    } t_out;

    typedef struct packed {
        logic signed [CW:0] dx;
        logic signed [CW:0] dy;
        logic [CW-2:0]      r;
        logic [CW-2:0]      w;
        logic [CW-2:0]      h;
    } t_geo;

    typedef struct packed {
        logic [LW-1:0] xd;
        logic [LW-1:0] yd;
        logic [CW-1:0] r2;
        logic [CW-2:0] w;
        logic [CW-2:0] h;
    } t_loc;

    function automatic logic [31:0] atan_phase(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0: v = 32'd536870912;  1: v = 32'd316933406;  2: v = 32'd167458907;
            3: v = 32'd85004756;   4: v = 32'd42667331;   5: v = 32'd21354465;
            6: v = 32'd10679838;   7: v = 32'd5340245;    8: v = 32'd2670163;
            9: v = 32'd1335087;    10: v = 32'd667544;    11: v = 32'd333772;
            12: v = 32'd166886;    13: v = 32'd83443;     14: v = 32'd41722;
            15: v = 32'd20861;     16: v = 32'd10430;     17: v = 32'd5215;
            18: v = 32'd2608;      19: v = 32'd1304;      20: v = 32'd652;
            21: v = 32'd326;       22: v = 32'd163;       23: v = 32'd81;
            24: v = 32'd41;        25: v = 32'd20;        26: v = 32'd10;
            27: v = 32'd5;         28: v = 32'd3;         29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/circle_rotated_rect_intersect_unit.sv -----
// Top level of the circle versus rotated rectangle intersection test.
// Depends on cri_pkg, cri_cordic, cri_rotate, cri_corner.
`default_nettype none
// Usage:
//   Drive an item on i_item and raise start; the item is taken at a rising
//   edge where start is high and busy is low. busy is low whenever reset is
//   released, so an item can enter every cycle.
//   Each item yields one result on o_result, marked by o_valid for exactly one
//   cycle. Results leave in item order.
//   Throughput: one item per cycle. The pipeline is the 30-stage CORDIC
//   (one iteration per stage), plus input, round/clamp, two rotation stages
//   (multiply, sum) and three decision stages (classify, square, compare).
//   The receiver cannot stall: results are shown once and must be taken.
//   Reset (synchronous, active low) clears every valid bit in the pipeline;
//   items in flight are dropped and no result comes out of them. busy is high
//   during reset so nothing is taken then.
//   Half sizes are handled exactly by comparing doubled local magnitudes with
//   the full width, height and diameter.
module circle_rotated_rect_intersect_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    input  wire cri_pkg::t_in i_item,
    output logic              busy,
    output logic              o_valid,
    output cri_pkg::t_out     o_result
);
    import cri_pkg::*;

    t_geo                 geo_in;
    logic                 cor_valid;
    logic signed [KW-1:0] cor_cos;
    logic signed [KW-1:0] cor_sin;
    t_geo                 cor_geo;
    logic                 rot_valid;
    t_loc                 rot_loc;

    // never hold items off outside reset
    assign busy = !i_rst_n;

    // offsets of the circle from the rectangle center, widened so nothing wraps
    assign geo_in.dx = (CW+1)'(i_item.circle_x) - (CW+1)'(i_item.rect_x);
    assign geo_in.dy = (CW+1)'(i_item.circle_y) - (CW+1)'(i_item.rect_y);
    assign geo_in.r  = i_item.circle_radius;
    assign geo_in.w  = i_item.rect_width;
    assign geo_in.h  = i_item.rect_height;

    cri_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start && !busy),
        .i_heading (i_item.rect_heading),
        .i_geo     (geo_in),
        .o_valid   (cor_valid),
        .o_cos     (cor_cos),
        .o_sin     (cor_sin),
        .o_geo     (cor_geo)
    );

    cri_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cor_valid),
        .i_cos   (cor_cos),
        .i_sin   (cor_sin),
        .i_geo   (cor_geo),
        .o_valid (rot_valid),
        .o_loc   (rot_loc)
    );

    cri_corner u_corner (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (rot_valid),
        .i_loc    (rot_loc),
        .o_valid  (o_valid),
        .o_result (o_result)
    );
endmodule
`default_nettype wire

// ----- rtl/cri_cordic.sv -----
// Pipelined rotation-mode CORDIC: one iteration per stage, then round, clamp, quadrant map.
// Carries the item geometry alongside. Depends on cri_pkg.
`default_nettype none
module cri_cordic (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [cri_pkg::AW-1:0] i_heading,
    input  wire cri_pkg::t_geo     i_geo,
    output logic                   o_valid,
    output logic signed [cri_pkg::KW-1:0] o_cos,
    output logic signed [cri_pkg::KW-1:0] o_sin,
    output cri_pkg::t_geo          o_geo
);
    import cri_pkg::*;

    logic signed [XW-1:0] r_x [0:STEPS];
    logic signed [XW-1:0] r_y [0:STEPS];
    logic signed [ZW-1:0] r_z [0:STEPS];
    logic [1:0]           r_q [0:STEPS];
    t_geo                 r_geo [0:STEPS];
    logic [STEPS:0]       r_v;
    logic [31:0]          phase;

    assign phase = 32'(i_heading) << (32 - AW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]   <= CORDIC_GAIN;
        r_y[0]   <= '0;
        r_z[0]   <= ZW'({2'b00, phase[29:0]});
        r_q[0]   <= phase[31:30];
        r_geo[0] <= i_geo;
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [ZW-1:0] ang;
        assign xs  = r_x[i] >>> i;
        assign ys  = r_y[i] >>> i;
        assign ang = ZW'(atan_phase(i));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
        end

        // rotate toward zero residual angle
        always_ff @(posedge i_clk) begin
            if (!r_z[i][ZW-1]) begin
                r_x[i+1] <= r_x[i] - ys;
                r_y[i+1] <= r_y[i] + xs;
                r_z[i+1] <= r_z[i] - ang;
            end else begin
                r_x[i+1] <= r_x[i] + ys;
                r_y[i+1] <= r_y[i] - xs;
                r_z[i+1] <= r_z[i] + ang;
            end
            r_q[i+1]   <= r_q[i];
            r_geo[i+1] <= r_geo[i];
        end
    end

    function automatic logic signed [KW-1:0] round_clamp(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        t = (v + XW'(8192)) >>> 14;
        if (t > XW'(65536)) return KW'(65536);
        if (t < -XW'(65536)) return -KW'(65536);
        return t[KW-1:0];
    endfunction

    logic signed [KW-1:0] cc;
    logic signed [KW-1:0] ss;
    logic signed [KW-1:0] n_cos;
    logic signed [KW-1:0] n_sin;

    assign cc = round_clamp(r_x[STEPS]);
    assign ss = round_clamp(r_y[STEPS]);

    always_comb begin
        case (r_q[STEPS])
            2'd0:    begin n_cos = cc;  n_sin = ss;  end
            2'd1:    begin n_cos = -ss; n_sin = cc;  end
            2'd2:    begin n_cos = -cc; n_sin = -ss; end
            default: begin n_cos = ss;  n_sin = -cc; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        o_cos <= n_cos;
        o_sin <= n_sin;
        o_geo <= r_geo[STEPS];
    end
endmodule
`default_nettype wire

// ----- rtl/cri_rotate.sv -----
// Frame rotation: four products in one stage, sums and rounded magnitudes in the next.
// Depends on cri_pkg.
`default_nettype none
module cri_rotate (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic signed [cri_pkg::KW-1:0] i_cos,
    input  wire logic signed [cri_pkg::KW-1:0] i_sin,
    input  wire cri_pkg::t_geo     i_geo,
    output logic                   o_valid,
    output cri_pkg::t_loc          o_loc
);
    import cri_pkg::*;

    localparam int PW = CW + 19;
    localparam int SW = CW + 20;

    logic                 r_v;
    logic signed [PW-1:0] r_pxc;
    logic signed [PW-1:0] r_pys;
    logic signed [PW-1:0] r_pxs;
    logic signed [PW-1:0] r_pyc;
    logic [CW-2:0]        r_r;
    logic [CW-2:0]        r_w;
    logic [CW-2:0]        r_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v     <= i_valid;
            o_valid <= r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pxc <= PW'(i_cos) * PW'(i_geo.dx);
        r_pys <= PW'(i_sin) * PW'(i_geo.dy);
        r_pxs <= PW'(i_sin) * PW'(i_geo.dx);
        r_pyc <= PW'(i_cos) * PW'(i_geo.dy);
        r_r   <= i_geo.r;
        r_w   <= i_geo.w;
        r_h   <= i_geo.h;
    end

    // round the magnitude of a signed Q35.16 sum to an integer, ties away from zero
    function automatic logic [CW+3:0] rnd_mag(input logic signed [SW-1:0] v);
        logic [SW-1:0] m;
        m = v[SW-1] ? SW'(-v) : SW'(v);
        m = (m + SW'(32768)) >> 16;
        return m[CW+3:0];
    endfunction

    logic signed [SW-1:0] sum_x;
    logic signed [SW-1:0] sum_y;
    assign sum_x = SW'(r_pxc) + SW'(r_pys);
    assign sum_y = SW'(r_pyc) - SW'(r_pxs);

    always_ff @(posedge i_clk) begin
        o_loc.xd <= {rnd_mag(sum_x), 1'b0};
        o_loc.yd <= {rnd_mag(sum_y), 1'b0};
        o_loc.r2 <= {r_r, 1'b0};
        o_loc.w  <= r_w;
        o_loc.h  <= r_h;
    end
endmodule
`default_nettype wire

// ----- rtl/cri_corner.sv -----
// Region decision, side tests and the corner distance test over three stages.
// Depends on cri_pkg.
`default_nettype none
module cri_corner (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire cri_pkg::t_loc i_loc,
    output logic               o_valid,
    output cri_pkg::t_out      o_result
);
    import cri_pkg::*;

    logic [1:0]      r_v;
    logic [1:0]      r_reg_c;
    logic            r_hit_c;
    logic            r_far_c;
    logic [CW-1:0]   r_a;
    logic [CW-1:0]   r_b;
    logic [CW-1:0]   r_r2_c;
    logic [1:0]      r_reg_d;
    logic            r_hit_d;
    logic            r_far_d;
    logic [2*CW-1:0] r_aa;
    logic [2*CW-1:0] r_bb;
    logic [2*CW-1:0] r_rr;

    logic [LW-1:0] w_e;
    logic [LW-1:0] h_e;
    logic [LW-1:0] r2_e;
    logic [LW-1:0] a_full;
    logic [LW-1:0] b_full;
    logic          x_in;
    logic          y_in;
    logic          x_out;
    logic          y_out;
    logic [1:0]    n_reg;
    logic          n_hit;

    assign w_e   = LW'(i_loc.w);
    assign h_e   = LW'(i_loc.h);
    assign r2_e  = LW'(i_loc.r2);
    assign x_in  = i_loc.xd < w_e;
    assign y_in  = i_loc.yd < h_e;
    assign x_out = i_loc.xd > w_e;
    assign y_out = i_loc.yd > h_e;
    assign a_full = x_out ? i_loc.xd - w_e : w_e - i_loc.xd;
    assign b_full = y_out ? i_loc.yd - h_e : h_e - i_loc.yd;

    always_comb begin
        if (x_in && y_in) begin
            n_reg = REGION_INSIDE;
            n_hit = 1'b1;
        end else if (x_in && y_out) begin
            n_reg = REGION_SIDE_Y;
            n_hit = i_loc.yd < h_e + r2_e;
        end else if (x_out && y_in) begin
            n_reg = REGION_SIDE_X;
            n_hit = i_loc.xd < w_e + r2_e;
        end else begin
            n_reg = REGION_CORNER;
            n_hit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            o_valid <= 1'b0;
        end else begin
            r_v     <= {r_v[0], i_valid};
            o_valid <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        // stage C: classify; offsets at or past 2r cannot hit, keep only low bits
        r_reg_c <= n_reg;
        r_hit_c <= n_hit;
        r_far_c <= (a_full >= r2_e) || (b_full >= r2_e);
        r_a     <= a_full[CW-1:0];
        r_b     <= b_full[CW-1:0];
        r_r2_c  <= i_loc.r2;
        // stage D: squares
        r_reg_d <= r_reg_c;
        r_hit_d <= r_hit_c;
        r_far_d <= r_far_c;
        r_aa    <= (2*CW)'(r_a) * (2*CW)'(r_a);
        r_bb    <= (2*CW)'(r_b) * (2*CW)'(r_b);
        r_rr    <= (2*CW)'(r_r2_c) * (2*CW)'(r_r2_c);
        // stage E: corner compare
        o_result.region <= r_reg_d;
        if (r_reg_d == REGION_CORNER) begin
            o_result.hit <= !r_far_d &&
                (((2*CW+1)'(r_aa) + (2*CW+1)'(r_bb)) < (2*CW+1)'(r_rr));
        end else begin
            o_result.hit <= r_hit_d;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/cri_checker.sv -----
// Port-level checks for the intersection unit, bound to the top level.
// Depends on cri_pkg and circle_rotated_rect_intersect_unit.
`default_nettype none
module cri_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          o_valid,
    input wire cri_pkg::t_out o_result
);
    import cri_pkg::*;

    localparam int LATENCY = 37;

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without an accepted item");

    a_item_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("accepted item produced no result");

    a_inside_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.region == REGION_INSIDE) |-> o_result.hit)
        else $error("inside region without hit");

    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised outside reset");
endmodule

bind circle_rotated_rect_intersect_unit cri_checker u_cri_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
`default_nettype wire
